@@ rtl/olie_pkg.sv @@
// ----------------------------------------------------------------------------
// olie_pkg - shared types and constants for the ordered list engine
// Beat structs, cell command, action and status codes.
// ----------------------------------------------------------------------------
package olie_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // action codes
  localparam logic [3:0] ACT_PUSH_BACK  = 4'd0;
  localparam logic [3:0] ACT_POP_BACK   = 4'd1;
  localparam logic [3:0] ACT_PUSH_FRONT = 4'd2;
  localparam logic [3:0] ACT_POP_FRONT  = 4'd3;
  localparam logic [3:0] ACT_INSERT     = 4'd4;
  localparam logic [3:0] ACT_ERASE      = 4'd5;
  localparam logic [3:0] ACT_FIND       = 4'd6;
  localparam logic [3:0] ACT_REMOVE     = 4'd7;
  localparam logic [3:0] ACT_CLEAR      = 4'd8;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [3:0]         action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } olie_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_index;
    logic [4:0] item_count;
  } olie_rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_CMP
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

@@ rtl/olie_cell.sv @@
// ----------------------------------------------------------------------------
// olie_cell - one list slot
// Holds one entry; shifts from a neighbor on open/close, registers a match.
// ----------------------------------------------------------------------------
module olie_cell import olie_pkg::*; (
  input  logic                  clk,
  input  logic [IDX_W-1:0]      idx,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] below,
  input  logic [DATA_WIDTH-1:0] above,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  match
);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_OPEN: begin
        if (idx > cmd.pos) begin
          entry <= below;
        end else if (idx == cmd.pos) begin
          entry <= cmd.value;
        end
      end
      CELL_CLOSE: begin
        if (idx >= cmd.pos) begin
          entry <= above;
        end
      end
      CELL_CMP: begin
        match <= (entry == cmd.value);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/olie_ctrl.sv @@
// ----------------------------------------------------------------------------
// olie_ctrl - request sequencer for the ordered list engine
// Compare on accept, then decide, drive the cell row and write the result.
// ----------------------------------------------------------------------------
module olie_ctrl import olie_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  olie_req_t        req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output olie_rsp_t        rsp,
  input  logic [DEPTH-1:0] match,
  output cell_cmd_t        cmd
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t           state;
  olie_req_t        held;
  logic [CNT_W-1:0] count;

  logic             slot_free;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [1:0]       status_c;
  logic [IDX_W-1:0] found_c;
  logic [CNT_W-1:0] count_next;
  cell_op_t         op_c;
  logic [IDX_W-1:0] pos_c;
  logic             full;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign full      = (count >= CNT_W'(DEPTH));

  // first live match
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i] && (CNT_W'(i) < count)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_c   = ST_DONE;
    found_c    = '0;
    count_next = count;
    op_c       = CELL_HOLD;
    pos_c      = '0;
    case (held.action)
      ACT_PUSH_BACK: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          op_c       = CELL_OPEN;
          pos_c      = count[IDX_W-1:0];
          count_next = count + 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (count == '0) begin
          status_c = ST_IGNORED;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          op_c       = CELL_OPEN;
          count_next = count + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (count == '0) begin
          status_c = ST_IGNORED;
        end else begin
          op_c       = CELL_CLOSE;
          count_next = count - 1'b1;
        end
      end
      ACT_INSERT: begin
        if (CNT_W'(held.position) > count) begin
          status_c = ST_IGNORED;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          op_c       = CELL_OPEN;
          pos_c      = held.position[IDX_W-1:0];
          count_next = count + 1'b1;
        end
      end
      ACT_ERASE: begin
        if (CNT_W'(held.position) >= count) begin
          status_c = ST_IGNORED;
        end else begin
          op_c       = CELL_CLOSE;
          pos_c      = held.position[IDX_W-1:0];
          count_next = count - 1'b1;
        end
      end
      ACT_FIND, ACT_REMOVE: begin
        if (!hit_found) begin
          status_c = ST_MISSING;
        end else begin
          found_c = hit_idx;
          if (held.action == ACT_REMOVE) begin
            op_c       = CELL_CLOSE;
            pos_c      = hit_idx;
            count_next = count - 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_c = ST_IGNORED;
      end
    endcase
  end

  // cell row command: compare against the incoming value while idle
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.pos   = pos_c;
    cmd.value = held.value[DATA_WIDTH-1:0];
    if (state == S_IDLE) begin
      cmd.op    = CELL_CMP;
      cmd.value = req.value[DATA_WIDTH-1:0];
    end else if (slot_free) begin
      cmd.op = op_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // in apply a taken beat is replaced below
      if (rsp_valid && !rsp_stall && (state != S_APPLY)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            held  <= req;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (slot_free) begin
            count           <= count_next;
            rsp.status      <= status_c;
            rsp.found_index <= 4'(found_c);
            rsp.item_count  <= 5'(count_next);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("accepted beat did not block the next one");

  a_count_in_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) && slot_free |=> rsp_valid && (5'(count) == rsp.item_count))
    else $error("result count differs from held count");

  a_full_means_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.item_count == 5'(DEPTH))
    else $error("full status with list not full");

  a_missing_zero_idx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_MISSING) |-> rsp.found_index == '0)
    else $error("miss with nonzero index");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> count <= CNT_W'(DEPTH))
    else $error("count past depth");
`endif

endmodule

@@ rtl/ordered_list_insert_erase_engine_core.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_engine_core - packed ordered list of signed words
// Each request is taken in a compare step across all cells, then held for a
//   decide/shift step that writes the result beat; a stalled result holds the
//   shift step, and no new request is taken until it completes.
// Reset: rst clears the count and both handshakes; cell contents are not reset
//   and only cells below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_engine_core import olie_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  olie_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output olie_rsp_t rsp
);

  // Row of DEPTH cells. Cell i sees cell i-1 (below) and cell i+1 (above):
  // an open shifts everything at and past the gap up by one, a close shifts
  // everything from the gap down by one, both as one registered update of every cell.
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]      match;

  olie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .match     (match),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] below;
    logic [DATA_WIDTH-1:0] above;

    // edge cells feed back on themselves; those values land only in
    // slots at or past the count
    if (i == 0) begin : g_lo
      assign below = entry[i];
    end else begin : g_lo_n
      assign below = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign above = entry[i];
    end else begin : g_hi_n
      assign above = entry[i+1];
    end

    olie_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .cmd   (cmd),
      .below (below),
      .above (above),
      .entry (entry[i]),
      .match (match[i])
    );
  end

endmodule
